[rtl/decimal_text_to_fixed_point_defines.svh]
// Assertion macros for the decimal text to fixed point checker.
// Every macro samples on clk; the first one is quiet while rst_n is low.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_DEFINES_SVH

// Property checked only when out of reset.
`define DTFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked during reset as well.
`define DTFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/dtfp_pkg.sv]
// Shared constants, types and the fraction weight table for the decimal
// text to fixed point block. No dependencies.
package dtfp_pkg;

  localparam int INT_BITS    = 31;
  localparam int FRAC_BITS   = 32;
  localparam int FRAC_DIGITS = 10;

  localparam int CH_W     = 8;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 16;
  localparam int MAG_W    = INT_BITS + FRAC_BITS;
  localparam int FACC_W   = FRAC_BITS + 1;
  localparam int FD_W     = $clog2(FRAC_DIGITS + 1);

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVF  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd2;

  localparam logic [MAG_W-1:0] MAX_MAG = {MAG_W{1'b1}};

  // round(2^32 / 10^k) for fraction digit k = 1..10
  localparam logic [FRAC_BITS-1:0] FRAC_WEIGHT [FRAC_DIGITS] = '{
    32'd429496730, 32'd42949673, 32'd4294967, 32'd429497, 32'd42950,
    32'd4295,      32'd429,      32'd43,      32'd4,      32'd0
  };

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    consumed;
  } dtfp_result_t;

endpackage

[rtl/dtfp_parse_core.sv]
// Parse state and next-state logic: one character per step.
// Depends on dtfp_pkg.
module dtfp_parse_core
  import dtfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [CH_W-1:0]    ch,
  input  logic               first,
  output logic               emit,
  output dtfp_result_t       res
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LEAD = 3'd1;
  localparam logic [2:0] PH_SIGN = 3'd2;
  localparam logic [2:0] PH_INT  = 3'd3;
  localparam logic [2:0] PH_DOT0 = 3'd4;
  localparam logic [2:0] PH_DOT1 = 3'd5;
  localparam logic [2:0] PH_FRAC = 3'd6;

  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CH_W-1:0] CH_CR    = 8'd13;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  logic [2:0]          phase_r, phase_nxt;
  logic                neg_r, neg_nxt;
  logic [INT_BITS-1:0] int_r, int_nxt;
  logic [FACC_W-1:0]   facc_r, facc_nxt;
  logic [FD_W-1:0]     fd_r, fd_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic [2:0]          ph;
  logic                neg_b;
  logic [INT_BITS-1:0] int_b;
  logic [FACC_W-1:0]   facc_b;
  logic [FD_W-1:0]     fd_b;
  logic [CNT_W-1:0]    cnt_b;

  logic                is_ws, is_sign, is_dot, is_digit;
  logic [3:0]          dig;
  logic [INT_BITS+3:0] int_mac;
  logic [1:0]          inc;
  logic [CNT_W:0]      cnt_sum;
  logic                do_sign, do_int, do_frac;
  logic                em_none, em_ovf, em_val;
  logic [INT_BITS:0]   int_up;
  logic [MAG_W-1:0]    mag;

  // first opens a fresh parse regardless of what is open
  assign ph     = first ? PH_LEAD : phase_r;
  assign neg_b  = first ? 1'b0 : neg_r;
  assign int_b  = first ? '0 : int_r;
  assign facc_b = first ? '0 : facc_r;
  assign fd_b   = first ? '0 : fd_r;
  assign cnt_b  = first ? '0 : cnt_r;

  assign is_ws    = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
  assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign is_dot   = (ch == CH_DOT);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dig      = is_digit ? 4'(ch - CH_ZERO) : 4'd0;
  // times ten as two shifts plus the digit
  assign int_mac  = {int_b, 3'b000} + {2'b00, int_b, 1'b0} + (INT_BITS+4)'(dig);

  always_comb begin
    phase_nxt = ph;
    neg_nxt   = neg_b;
    int_nxt   = int_b;
    facc_nxt  = facc_b;
    fd_nxt    = fd_b;
    inc       = 2'd0;
    do_sign   = 1'b0;
    do_int    = 1'b0;
    do_frac   = 1'b0;
    em_none   = 1'b0;
    em_ovf    = 1'b0;
    em_val    = 1'b0;

    unique case (ph) inside
      PH_IDLE: ;
      PH_LEAD: begin
        if (is_ws) begin
          inc = 2'd1;
        end else if (is_sign) begin
          neg_nxt   = (ch == CH_MINUS);
          inc       = 2'd1;
          phase_nxt = PH_SIGN;
        end else begin
          do_sign = 1'b1;
        end
      end
      PH_SIGN: do_sign = 1'b1;
      PH_INT:  do_int  = 1'b1;
      PH_DOT0, PH_DOT1: begin
        if (!is_digit) begin
          em_none = (ph == PH_DOT0);
          em_val  = (ph == PH_DOT1);
        end else begin
          // the dot counts once a digit follows it
          inc     = 2'd1;
          do_frac = 1'b1;
        end
      end
      PH_FRAC: do_frac = 1'b1;
      default: ;
    endcase

    if (do_sign) begin
      if (is_dot) begin
        phase_nxt = PH_DOT0;
      end else if (!is_digit) begin
        em_none = 1'b1;
      end else begin
        do_int = 1'b1;
      end
    end

    if (do_int) begin
      if (is_digit) begin
        inc = inc + 2'd1;
        if (int_mac[INT_BITS+3:INT_BITS] != '0) begin
          em_ovf = 1'b1;
        end else begin
          int_nxt   = int_mac[INT_BITS-1:0];
          phase_nxt = PH_INT;
        end
      end else if (is_dot) begin
        phase_nxt = PH_DOT1;
      end else begin
        em_val = 1'b1;
      end
    end

    if (do_frac) begin
      if (is_digit) begin
        inc       = inc + 2'd1;
        phase_nxt = PH_FRAC;
        if (fd_b < FD_W'(FRAC_DIGITS)) begin
          fd_nxt   = fd_b + FD_W'(1);
          facc_nxt = facc_b + FACC_W'(dig * FRAC_WEIGHT[fd_b]);
        end
      end else begin
        em_val = 1'b1;
      end
    end

    if (em_none) begin
      neg_nxt = 1'b0;
    end
    if (em_none || em_ovf || em_val) begin
      phase_nxt = PH_IDLE;
    end
  end

  assign cnt_sum = {1'b0, cnt_b} + (CNT_W+1)'(inc);
  assign cnt_nxt = cnt_sum[CNT_W] ? {CNT_W{1'b1}} : cnt_sum[CNT_W-1:0];

  // fraction carry lands on the integer part; clamp if it runs out
  assign int_up = {1'b0, int_nxt} + (INT_BITS+1)'(facc_nxt[FRAC_BITS]);

  always_comb begin
    if (em_ovf || int_up[INT_BITS]) begin
      mag = MAX_MAG;
    end else begin
      mag = {int_up[INT_BITS-1:0], facc_nxt[FRAC_BITS-1:0]};
    end
  end

  assign emit = em_none || em_ovf || em_val;

  always_comb begin
    res.value    = '0;
    res.status   = STATUS_NONE;
    res.consumed = '0;
    if (!em_none) begin
      res.value    = neg_nxt ? -VALUE_W'(mag) : VALUE_W'(mag);
      res.status   = em_ovf ? STATUS_OVF : STATUS_OK;
      res.consumed = cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (step) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      neg_r  <= neg_nxt;
      int_r  <= int_nxt;
      facc_r <= facc_nxt;
      fd_r   <= fd_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[rtl/dtfp_out_stage.sv]
// Result register on the master side: holds a finished result until taken.
// Depends on dtfp_pkg.
module dtfp_out_stage
  import dtfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  dtfp_result_t res,
  output logic         free,
  output logic         out_tvalid,
  input  logic         out_tready,
  output dtfp_result_t res_q
);

  logic         vld_r;
  dtfp_result_t res_r;

  // room this cycle if empty or draining
  assign free       = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign res_q      = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (free) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res;
    end
  end

endmodule

[rtl/decimal_text_to_fixed_point.sv]
// Decimal text to signed fixed point (Q31.32) stream converter, top level.
// Depends on dtfp_pkg, dtfp_parse_core and dtfp_out_stage.
//
// One ASCII character per beat; in_tuser marks the first character of a new
// number. A character that does not fit the number ends it and yields one
// result beat with the value, a status and the count of consumed characters;
// every other character yields none. The block takes one character every
// clock cycle unless a held result beat stalls it. A character is captured in
// the input register, then a single step of the parse logic (multiply-by-ten
// add on the integer part, digit-times-weight add on the fraction) writes
// the result register. A result beat held by out_tready low stalls both
// registers; with out_tready high no bubbles.
module decimal_text_to_fixed_point
  import dtfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] ch
  input  logic [0:0]            in_tuser,   // [0] first
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [79:0]           out_tdata,  // [63:0] value, [79:64] consumed
  output logic [STATUS_W-1:0]   out_tuser   // [1:0] status
);

  logic            in_vld_r;
  logic [CH_W-1:0] in_ch_r;
  logic            in_first_r;
  logic            out_free;
  logic            step;
  logic            emit;
  dtfp_result_t    res;
  dtfp_result_t    res_q;

  assign step      = in_vld_r && out_free;
  assign in_tready = !in_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_ch_r    <= in_tdata[CH_W-1:0];
      in_first_r <= in_tuser[0];
    end
  end

  dtfp_parse_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .ch    (in_ch_r),
    .first (in_first_r),
    .emit  (emit),
    .res   (res)
  );

  dtfp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && emit),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res_q      (res_q)
  );

  assign out_tdata = {res_q.consumed, res_q.value};
  assign out_tuser = res_q.status;

endmodule

[rtl/dtfp_checker.sv]
// Port-level checks for decimal_text_to_fixed_point, bound to the top level.
// Depends on dtfp_pkg and decimal_text_to_fixed_point_defines.svh.
`include "decimal_text_to_fixed_point_defines.svh"

module dtfp_checker
  import dtfp_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [79:0]         out_tdata,
  input logic [STATUS_W-1:0] out_tuser
);

  localparam logic [VALUE_W-1:0] POS_MAX = VALUE_W'(MAX_MAG);
  localparam logic [VALUE_W-1:0] NEG_MAX = -VALUE_W'(MAX_MAG);

  `DTFP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed while stalled")
  `DTFP_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_tvalid, "result beat right after reset")
  `DTFP_ASSERT(a_none_zero, out_tvalid && out_tuser == STATUS_NONE |-> out_tdata == '0, "empty parse with nonzero value or count")
  `DTFP_ASSERT(a_ovf_sat, out_tvalid && out_tuser == STATUS_OVF |-> (out_tdata[63:0] == POS_MAX || out_tdata[63:0] == NEG_MAX) && out_tdata[79:64] != '0, "overflow result not saturated")

endmodule

bind decimal_text_to_fixed_point dtfp_checker u_dtfp_checker (.*);
